[hw/rtl/great_circle_angular_distance_unit_assert.svh]
// Assertion macros for the great-circle angular distance unit.
// Expects signals named clock and reset in the module that includes it.
`ifndef GREAT_CIRCLE_ANGULAR_DISTANCE_UNIT_ASSERT_SVH
`define GREAT_CIRCLE_ANGULAR_DISTANCE_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define GCAD_ASSERT_IMPL(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define GCAD_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

[hw/rtl/gcad_pkg.sv]
// Shared constants for the great-circle angular distance unit.
// No dependencies; used by gcad_sin, the top level and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package gcad_pkg;

   // Angle fields are in units of 2^-ANGLE_FRAC_BITS degree.
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int RA_W  = 25;
   localparam int DEC_W = 24;
   localparam int SEP_W = 24;

   // Raw angle magnitudes after differencing and range reduction.
   localparam int RAW_W = 25;

   // Q1.30 trig values, which reach exactly 1.0.
   localparam int Q_FRAC = 30;
   localparam int Q_W    = Q_FRAC + 1;
   localparam logic [Q_W-1:0] ONE_Q = {1'b1, {Q_FRAC{1'b0}}};

   // Sine arguments are in units of 2^-26 degree, at most 90 degree.
   localparam int ARG_W = 33;
   localparam logic [ARG_W-1:0] DEG90_ARG = ARG_W'(64'd90 << 26);

   // round(pi/180 * 2^36): degree to radian scaling.
   localparam logic [30:0] RAD_K = 31'd1199381129;

   // Taylor series in Horner form. The divisors 156, 110, 72, 42, 20 and 6
   // are applied as exact reciprocal multiplications for 32-bit dividends.
   localparam int TAYLOR_N = 6;
   localparam int P_W      = 32;
   localparam logic [32:0] TAYLOR_MUL [TAYLOR_N] = '{
      33'd7048151461, 33'd4997780127, 33'd7635497416,
      33'd6544712071, 33'd6871947674, 33'd5726623062
   };
   localparam int TAYLOR_SHIFT [TAYLOR_N] = '{40, 39, 39, 38, 37, 35};

   // Register levels in one sine pipeline.
   localparam int SIN_LAT = 2 * TAYLOR_N + 2;

   // Shifts from raw units to sine argument units.
   localparam int HALF_SH = 25 - ANGLE_FRAC_BITS;
   localparam int COS_SH  = 26 - ANGLE_FRAC_BITS;

   // Range reduction bounds in raw units.
   localparam logic [RAW_W-1:0] HALF_MOD  = RAW_W'(180 << (ANGLE_FRAC_BITS + 1));
   localparam logic [RAW_W-1:0] HALF_FOLD = RAW_W'(90 << (ANGLE_FRAC_BITS + 1));
   localparam logic [RAW_W-1:0] COS_MOD   = RAW_W'(360 << ANGLE_FRAC_BITS);
   localparam logic [RAW_W-1:0] COS_HALF  = RAW_W'(180 << ANGLE_FRAC_BITS);
   localparam logic [RAW_W-1:0] COS_QTR   = RAW_W'(90 << ANGLE_FRAC_BITS);

   // Largest separation, 180 degree.
   localparam logic [SEP_W-1:0] SEP_LIMIT = SEP_W'(180 << ANGLE_FRAC_BITS);

   // Square root remainder width.
   localparam int REM_W = 2 * Q_W;

endpackage

`default_nettype wire

[hw/rtl/gcad_sin.sv]
// Pipelined fixed-point sine for 0..90 degree, result in Q1.30.
// Depends on gcad_pkg. The pipeline advances only when enable is high.
`timescale 1ns / 1ps
`default_nettype none

module gcad_sin (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [gcad_pkg::ARG_W-1:0] angle,
   output logic [gcad_pkg::Q_W-1:0]   sine
);
   import gcad_pkg::*;

   localparam int XLAST = 2 * TAYLOR_N;

   logic [ARG_W-1:0] a_clamp;
   logic [63:0]      x_prod;
   logic [61:0]      x2_prod;
   logic [61:0]      s_prod;
   logic [P_W-1:0]   s_raw;

   logic [Q_W-1:0] x_ff  [0:XLAST];
   logic [P_W-1:0] x2_ff [1:XLAST-2];
   logic [Q_W-1:0] t_ff  [0:TAYLOR_N-1];
   logic [P_W-1:0] p_ff  [1:TAYLOR_N-1];
   logic [Q_W-1:0] sine_ff;

   assign a_clamp = (angle > DEG90_ARG) ? DEG90_ARG : angle;
   assign x_prod  = 64'(a_clamp) * 64'(RAD_K);
   assign x2_prod = 62'(x_ff[0]) * 62'(x_ff[0]);

   // Angle in radians and its square travel alongside the Horner terms.
   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]  <= x_prod[Q_FRAC+32:32];
         x2_ff[1] <= x2_prod[61:30];
         for (int j = 1; j <= XLAST; j++) begin
            x_ff[j] <= x_ff[j-1];
         end
         for (int j = 2; j <= XLAST - 2; j++) begin
            x2_ff[j] <= x2_ff[j-1];
         end
      end
   end

   for (genvar k = 0; k < TAYLOR_N; k++) begin : g_term
      logic [P_W-1:0] p_src;
      logic [64:0]    q_prod;
      logic [Q_W-1:0] quot;

      if (k == 0) begin : g_first
         assign p_src = x2_ff[1];
      end else begin : g_next
         logic [62:0] p_prod;
         assign p_prod = 63'(x2_ff[2*k]) * 63'(t_ff[k-1]);
         always_ff @(posedge clock) begin
            if (enable) begin
               p_ff[k] <= p_prod[61:30];
            end
         end
         assign p_src = p_ff[k];
      end

      assign q_prod = 65'(p_src) * 65'(TAYLOR_MUL[k]);
      assign quot   = Q_W'(q_prod >> TAYLOR_SHIFT[k]);

      always_ff @(posedge clock) begin
         if (enable) begin
            t_ff[k] <= ONE_Q - quot;
         end
      end
   end

   assign s_prod = 62'(x_ff[XLAST]) * 62'(t_ff[TAYLOR_N-1]);
   assign s_raw  = s_prod[61:30];

   always_ff @(posedge clock) begin
      if (enable) begin
         sine_ff <= (s_raw > {1'b0, ONE_Q}) ? ONE_Q : s_raw[Q_W-1:0];
      end
   end

   assign sine = sine_ff;

endmodule

`default_nettype wire

[hw/rtl/great_circle_angular_distance_unit.sv]
// Great-circle angle between two sky positions by the haversine formula.
// Depends on gcad_pkg, gcad_sin and great_circle_angular_distance_unit_assert.svh.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | ra_first, dec_first, ra_second, dec_second
//   rsp     | out       | rsp_valid/rsp_ready  | separation
//
// One beat enters per clock while req_ready is high; its result passes 3 front stages,
// one 14-stage sine pipeline, 3 product stages, 31 square-root stages (one root
// bit each) and 24 arcsine steps (sine pipeline plus a compare).
// Reset clears only valid bits and the full flag of the output skid register.
// When rsp stalls, the output skid register takes one result and the whole
// pipeline then freezes, with req_ready low, until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module great_circle_angular_distance_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [gcad_pkg::RA_W-1:0]         req_ra_first,
   input  logic signed [gcad_pkg::DEC_W-1:0] req_dec_first,
   input  logic [gcad_pkg::RA_W-1:0]         req_ra_second,
   input  logic signed [gcad_pkg::DEC_W-1:0] req_dec_second,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [gcad_pkg::SEP_W-1:0]        rsp_separation
);
   import gcad_pkg::*;

   // ------------------------------------------------------------------
   // Flow control. The pipeline moves as one while the skid register is
   // empty; a result that is not taken drops into the skid register.
   // ------------------------------------------------------------------
   logic             pipe_adv;
   logic             skid_full_ff, skid_full_in;
   logic [SEP_W-1:0] skid_sep_ff;
   logic             last_vld;
   logic [SEP_W-1:0] last_sep;

   assign pipe_adv  = !skid_full_ff;
   assign req_ready = pipe_adv;

   // ------------------------------------------------------------------
   // Front stage 1: magnitudes of the RA and declination differences and
   // of each declination.
   // ------------------------------------------------------------------
   logic signed [RAW_W-1:0] d1_ext, d2_ext, dd_ab, dd_ba;
   logic [RAW_W-1:0] ra_mag_in, dec_mag_in, c1_mag_in, c2_mag_in;
   logic [RAW_W-1:0] ra_mag_ff, dec_mag_ff, c1_mag_ff, c2_mag_ff;
   logic             p1_vld_ff;

   assign d1_ext = RAW_W'(req_dec_first);
   assign d2_ext = RAW_W'(req_dec_second);
   assign dd_ab  = d1_ext - d2_ext;
   assign dd_ba  = d2_ext - d1_ext;

   assign ra_mag_in  = (req_ra_first >= req_ra_second)
                       ? RAW_W'(req_ra_first - req_ra_second)
                       : RAW_W'(req_ra_second - req_ra_first);
   assign dec_mag_in = (req_dec_first >= req_dec_second) ? dd_ab : dd_ba;
   assign c1_mag_in  = d1_ext[RAW_W-1] ? RAW_W'(-d1_ext) : d1_ext;
   assign c2_mag_in  = d2_ext[RAW_W-1] ? RAW_W'(-d2_ext) : d2_ext;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         ra_mag_ff  <= ra_mag_in;
         dec_mag_ff <= dec_mag_in;
         c1_mag_ff  <= c1_mag_in;
         c2_mag_ff  <= c2_mag_in;
      end
   end

   // ------------------------------------------------------------------
   // Front stage 2: the half-angle terms wrap at 360 degree of difference;
   // the cosine arguments wrap at 360 degree and fold onto 0..180.
   // ------------------------------------------------------------------
   logic [RAW_W-1:0] ra_red_in, dec_red_in, c1_wrap, c2_wrap, c1_red_in, c2_red_in;
   logic [RAW_W-1:0] ra_red_ff, dec_red_ff, c1_red_ff, c2_red_ff;
   logic             p2_vld_ff;

   assign ra_red_in  = (ra_mag_ff >= HALF_MOD) ? ra_mag_ff - HALF_MOD : ra_mag_ff;
   assign dec_red_in = (dec_mag_ff >= HALF_MOD) ? dec_mag_ff - HALF_MOD : dec_mag_ff;
   assign c1_wrap    = (c1_mag_ff >= COS_MOD) ? c1_mag_ff - COS_MOD : c1_mag_ff;
   assign c2_wrap    = (c2_mag_ff >= COS_MOD) ? c2_mag_ff - COS_MOD : c2_mag_ff;
   assign c1_red_in  = (c1_wrap > COS_HALF) ? COS_MOD - c1_wrap : c1_wrap;
   assign c2_red_in  = (c2_wrap > COS_HALF) ? COS_MOD - c2_wrap : c2_wrap;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         ra_red_ff  <= ra_red_in;
         dec_red_ff <= dec_red_in;
         c1_red_ff  <= c1_red_in;
         c2_red_ff  <= c2_red_in;
      end
   end

   // ------------------------------------------------------------------
   // Front stage 3: fold onto 0..90 degree and form the sine arguments.
   // A cosine past 90 degree is taken as the negative of its mirror, and
   // only whether the two cosine signs differ is kept.
   // ------------------------------------------------------------------
   logic             c1_neg, c2_neg;
   logic [RAW_W-1:0] ra_fold, dec_fold, c1_fold, c2_fold;
   logic [ARG_W-1:0] arg_ra_ff, arg_dec_ff, arg_c1_ff, arg_c2_ff;
   logic             ndiff_ff;
   logic             p3_vld_ff;

   assign ra_fold  = (ra_red_ff > HALF_FOLD) ? HALF_MOD - ra_red_ff : ra_red_ff;
   assign dec_fold = (dec_red_ff > HALF_FOLD) ? HALF_MOD - dec_red_ff : dec_red_ff;
   assign c1_neg   = c1_red_ff > COS_QTR;
   assign c2_neg   = c2_red_ff > COS_QTR;
   assign c1_fold  = c1_neg ? COS_HALF - c1_red_ff : c1_red_ff;
   assign c2_fold  = c2_neg ? COS_HALF - c2_red_ff : c2_red_ff;

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         arg_ra_ff  <= ARG_W'(ra_fold) << HALF_SH;
         arg_dec_ff <= ARG_W'(dec_fold) << HALF_SH;
         arg_c1_ff  <= ARG_W'(COS_QTR - c1_fold) << COS_SH;
         arg_c2_ff  <= ARG_W'(COS_QTR - c2_fold) << COS_SH;
         ndiff_ff   <= c1_neg ^ c2_neg;
      end
   end

   // ------------------------------------------------------------------
   // Four sines in parallel: the two half-angle sines and two cosines.
   // ------------------------------------------------------------------
   logic [Q_W-1:0] s_ra, s_dec, s_c1, s_c2;
   logic           fd_vld_ff   [0:SIN_LAT-1];
   logic           fd_ndiff_ff [0:SIN_LAT-1];

   gcad_sin u_sin_ra  (.clock(clock), .enable(pipe_adv), .angle(arg_ra_ff),  .sine(s_ra));
   gcad_sin u_sin_dec (.clock(clock), .enable(pipe_adv), .angle(arg_dec_ff), .sine(s_dec));
   gcad_sin u_cos_1   (.clock(clock), .enable(pipe_adv), .angle(arg_c1_ff),  .sine(s_c1));
   gcad_sin u_cos_2   (.clock(clock), .enable(pipe_adv), .angle(arg_c2_ff),  .sine(s_c2));

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         fd_ndiff_ff[0] <= ndiff_ff;
         for (int j = 1; j < SIN_LAT; j++) begin
            fd_ndiff_ff[j] <= fd_ndiff_ff[j-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Products: squares of the half-angle sines and the cosine product,
   // then the weighted RA term, then the clamped haversine sum or difference.
   // ------------------------------------------------------------------
   logic [61:0]    sq_ra_prod, sq_dec_prod, cprod_prod, term_prod;
   logic [Q_W-1:0] sq_ra_ff, sq_dec_ff, cprod_ff, term_ff, sq_dec2_ff;
   logic           m1_ndiff_ff, m2_ndiff_ff;
   logic           m1_vld_ff, m2_vld_ff;
   logic [Q_W:0]   hav_sum;
   logic [Q_W-1:0] h_in, h_ff;
   logic           h_vld_ff;

   assign sq_ra_prod  = 62'(s_ra) * 62'(s_ra);
   assign sq_dec_prod = 62'(s_dec) * 62'(s_dec);
   assign cprod_prod  = 62'(s_c1) * 62'(s_c2);
   assign term_prod   = 62'(cprod_ff) * 62'(sq_ra_ff);

   assign hav_sum = {1'b0, sq_dec2_ff} + {1'b0, term_ff};

   always_comb begin
      if (m2_ndiff_ff) begin
         h_in = (term_ff > sq_dec2_ff) ? '0 : sq_dec2_ff - term_ff;
      end else begin
         h_in = (hav_sum > {1'b0, ONE_Q}) ? ONE_Q : hav_sum[Q_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_adv) begin
         sq_ra_ff    <= sq_ra_prod[Q_FRAC+Q_W-1:Q_FRAC];
         sq_dec_ff   <= sq_dec_prod[Q_FRAC+Q_W-1:Q_FRAC];
         cprod_ff    <= cprod_prod[Q_FRAC+Q_W-1:Q_FRAC];
         m1_ndiff_ff <= fd_ndiff_ff[SIN_LAT-1];
         term_ff     <= term_prod[Q_FRAC+Q_W-1:Q_FRAC];
         sq_dec2_ff  <= sq_dec_ff;
         m2_ndiff_ff <= m1_ndiff_ff;
         h_ff        <= h_in;
      end
   end

   // ------------------------------------------------------------------
   // Square root of h * 2^30, one root bit per stage, MSB first.
   // ------------------------------------------------------------------
   logic [REM_W-1:0] sq_rem_ff  [0:Q_W-1];
   logic [Q_W-1:0]   sq_root_ff [0:Q_W-1];
   logic             sq_vld_ff  [0:Q_W-1];

   for (genvar j = 0; j < Q_W; j++) begin : g_sqrt
      localparam int BI = Q_W - 1 - j;
      logic [REM_W-1:0] rem_src, trial;
      logic [Q_W-1:0]   root_src;

      if (j == 0) begin : g_first
         assign rem_src  = REM_W'(h_ff) << Q_FRAC;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = sq_rem_ff[j-1];
         assign root_src = sq_root_ff[j-1];
      end

      assign trial = (REM_W'(root_src) << (BI + 1)) | (REM_W'(1) << (2 * BI));

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            if (rem_src >= trial) begin
               sq_rem_ff[j]  <= rem_src - trial;
               sq_root_ff[j] <= root_src | (Q_W'(1) << BI);
            end else begin
               sq_rem_ff[j]  <= rem_src;
               sq_root_ff[j] <= root_src;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Arcsine by bitwise search: each step tries one more separation bit,
   // keeping it when the candidate is within 180 degree and the sine of
   // its half does not exceed the root.
   // ------------------------------------------------------------------
   logic [SEP_W-1:0] as_sep_ff  [0:SEP_W-1];
   logic [Q_W-1:0]   as_root_ff [0:SEP_W-1];
   logic             as_vld_ff  [0:SEP_W-1];

   for (genvar k = 0; k < SEP_W; k++) begin : g_asin
      localparam int BIT = SEP_W - 1 - k;
      logic [SEP_W-1:0] src_sep, cand_in, cand_out;
      logic [Q_W-1:0]   src_root, sine;
      logic             src_vld, hit;
      logic [SEP_W-1:0] dl_sep_ff  [0:SIN_LAT-1];
      logic [Q_W-1:0]   dl_root_ff [0:SIN_LAT-1];
      logic             dl_ok_ff   [0:SIN_LAT-1];
      logic             dl_vld_ff  [0:SIN_LAT-1];

      if (k == 0) begin : g_first
         assign src_sep  = '0;
         assign src_root = sq_root_ff[Q_W-1];
         assign src_vld  = sq_vld_ff[Q_W-1];
      end else begin : g_next
         assign src_sep  = as_sep_ff[k-1];
         assign src_root = as_root_ff[k-1];
         assign src_vld  = as_vld_ff[k-1];
      end

      assign cand_in = src_sep | (SEP_W'(1) << BIT);

      gcad_sin u_sin (
         .clock  (clock),
         .enable (pipe_adv),
         .angle  (ARG_W'(cand_in) << HALF_SH),
         .sine   (sine)
      );

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            dl_sep_ff[0]  <= src_sep;
            dl_root_ff[0] <= src_root;
            dl_ok_ff[0]   <= cand_in <= SEP_LIMIT;
            for (int j = 1; j < SIN_LAT; j++) begin
               dl_sep_ff[j]  <= dl_sep_ff[j-1];
               dl_root_ff[j] <= dl_root_ff[j-1];
               dl_ok_ff[j]   <= dl_ok_ff[j-1];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            for (int j = 0; j < SIN_LAT; j++) begin
               dl_vld_ff[j] <= 1'b0;
            end
            as_vld_ff[k] <= 1'b0;
         end else if (pipe_adv) begin
            dl_vld_ff[0] <= src_vld;
            for (int j = 1; j < SIN_LAT; j++) begin
               dl_vld_ff[j] <= dl_vld_ff[j-1];
            end
            as_vld_ff[k] <= dl_vld_ff[SIN_LAT-1];
         end
      end

      assign cand_out = dl_sep_ff[SIN_LAT-1] | (SEP_W'(1) << BIT);
      assign hit      = dl_ok_ff[SIN_LAT-1] && (sine <= dl_root_ff[SIN_LAT-1]);

      always_ff @(posedge clock) begin
         if (pipe_adv) begin
            as_sep_ff[k]  <= hit ? cand_out : dl_sep_ff[SIN_LAT-1];
            as_root_ff[k] <= dl_root_ff[SIN_LAT-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Valid bits of the front, sine, product and square-root stages.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         for (int j = 0; j < SIN_LAT; j++) begin
            fd_vld_ff[j] <= 1'b0;
         end
         m1_vld_ff <= 1'b0;
         m2_vld_ff <= 1'b0;
         h_vld_ff  <= 1'b0;
         for (int j = 0; j < Q_W; j++) begin
            sq_vld_ff[j] <= 1'b0;
         end
      end else if (pipe_adv) begin
         p1_vld_ff    <= req_valid;
         p2_vld_ff    <= p1_vld_ff;
         p3_vld_ff    <= p2_vld_ff;
         fd_vld_ff[0] <= p3_vld_ff;
         for (int j = 1; j < SIN_LAT; j++) begin
            fd_vld_ff[j] <= fd_vld_ff[j-1];
         end
         m1_vld_ff    <= fd_vld_ff[SIN_LAT-1];
         m2_vld_ff    <= m1_vld_ff;
         h_vld_ff     <= m2_vld_ff;
         sq_vld_ff[0] <= h_vld_ff;
         for (int j = 1; j < Q_W; j++) begin
            sq_vld_ff[j] <= sq_vld_ff[j-1];
         end
      end
   end

   // ------------------------------------------------------------------
   // Output skid register.
   // ------------------------------------------------------------------
   assign last_vld = as_vld_ff[SEP_W-1];
   assign last_sep = as_sep_ff[SEP_W-1];

   assign skid_full_in = skid_full_ff ? !rsp_ready : (last_vld && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
      end else begin
         skid_full_ff <= skid_full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!skid_full_ff) begin
         skid_sep_ff <= last_sep;
      end
   end

   assign rsp_valid      = skid_full_ff || last_vld;
   assign rsp_separation = skid_full_ff ? skid_sep_ff : last_sep;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
`include "great_circle_angular_distance_unit_assert.svh"

   `GCAD_ASSERT_IMPL(a_sep_range, rsp_valid, rsp_separation <= SEP_LIMIT, "separation beyond 180 degree")
   `GCAD_ASSERT_IMPL(a_hav_clamp, h_vld_ff, h_ff <= ONE_Q, "haversine term above one")
   `GCAD_ASSERT_NEXT(a_skid_hold, skid_full_ff && !rsp_ready, skid_full_ff && $stable(skid_sep_ff), "skid result lost")
   `GCAD_ASSERT_NEXT(a_stall_freeze, !pipe_adv, $stable(as_vld_ff[SEP_W-1]), "pipeline moved while stalled")

endmodule

`default_nettype wire

[tb/sv/tb_great_circle_angular_distance_unit.sv]
// Self-checking testbench for great_circle_angular_distance_unit.
// Depends on gcad_pkg and the unit itself; predicts each separation bit for bit.
`timescale 1ns / 1ps
`default_nettype none

module tb_great_circle_angular_distance_unit;
   import gcad_pkg::*;

   localparam int    PERIOD     = 4;
   localparam int    RESET_CYC  = 9;
   localparam int    LATENCY    = 411;
   localparam int    N_RANDOM   = 1200;
   localparam int    QUIET_TAIL = 150;
   localparam longint CYCLE_LIMIT = 400000;

   localparam longint unsigned Q_ONE  = 64'd1 << 30;
   localparam longint unsigned A90    = 64'd90 << 26;
   localparam longint unsigned A180   = 64'd180 << 26;
   localparam longint unsigned A360   = 64'd360 << 26;
   localparam longint unsigned RADK   = 64'd1199381129;

   typedef struct packed {
      logic [RA_W-1:0]         ra_first;
      logic signed [DEC_W-1:0] dec_first;
      logic [RA_W-1:0]         ra_second;
      logic signed [DEC_W-1:0] dec_second;
   } sky_pair_t;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [RA_W-1:0]           req_ra_first;
   logic signed [DEC_W-1:0]   req_dec_first;
   logic [RA_W-1:0]           req_ra_second;
   logic signed [DEC_W-1:0]   req_dec_second;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic [SEP_W-1:0]          rsp_separation;

   great_circle_angular_distance_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_ra_first   (req_ra_first),
      .req_dec_first  (req_dec_first),
      .req_ra_second  (req_ra_second),
      .req_dec_second (req_dec_second),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_separation (rsp_separation)
   );

   // Pairs waiting to be driven, and separations waiting to come back.
   sky_pair_t        pending_pairs[$];
   logic [SEP_W-1:0] expected_separations[$];
   int               error_count = 0;
   longint           cycle_count = 0;

   // Sine of an angle in 2^-26 degree units over 0..90 degree, in Q30.
   // The Taylor series is evaluated in Horner form with truncating products.
   function automatic longint unsigned sine_q30(longint unsigned a);
      longint unsigned x, x2, t, s;
      int unsigned divs[6];
      divs = '{156, 110, 72, 42, 20, 6};
      if (a > A90) a = A90;
      x  = (a * RADK) >> 32;
      x2 = (x * x) >> 30;
      t  = Q_ONE;
      for (int i = 0; i < 6; i++) t = Q_ONE - ((x2 * t) >> 30) / divs[i];
      s = (x * t) >> 30;
      return (s > Q_ONE) ? Q_ONE : s;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   // Squared sine of half a raw angle difference; period 360 degree.
   function automatic longint unsigned half_sine_sq(longint diff);
      longint unsigned m, s;
      m = magnitude(diff) << (25 - ANGLE_FRAC_BITS);
      m = m % A180;
      if (m > A90) m = A180 - m;
      s = sine_q30(m);
      return (s * s) >> 30;
   endfunction

   // Cosine magnitude of a raw declination, with its sign returned apart.
   function automatic longint unsigned cosine_mag(longint d, output bit negative);
      longint unsigned m;
      m = magnitude(d) << (26 - ANGLE_FRAC_BITS);
      m = m % A360;
      if (m > A180) m = A360 - m;
      negative = (m > A90);
      if (negative) m = A180 - m;
      return sine_q30(A90 - m);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // Haversine separation, floored, with the haversine clamped to [0, 1].
   function automatic logic [SEP_W-1:0] predict_separation(sky_pair_t p);
      longint          ra1, ra2, d1, d2;
      longint unsigned sq_ra, sq_dec, c1, c2, term, h, root, sep, cand, lim;
      bit              n1, n2;
      ra1 = longint'(p.ra_first);
      ra2 = longint'(p.ra_second);
      d1  = longint'(p.dec_first);
      d2  = longint'(p.dec_second);
      sq_ra  = half_sine_sq(ra1 - ra2);
      sq_dec = half_sine_sq(d1 - d2);
      c1 = cosine_mag(d1, n1);
      c2 = cosine_mag(d2, n2);
      term = (((c1 * c2) >> 30) * sq_ra) >> 30;
      if (n1 != n2) h = (term > sq_dec) ? 0 : sq_dec - term;
      else h = sq_dec + term;
      if (h > Q_ONE) h = Q_ONE;
      root = int_sqrt(h << 30);
      sep = 0;
      lim = 64'd180 << ANGLE_FRAC_BITS;
      for (int b = ANGLE_FRAC_BITS + 7; b >= 0; b--) begin
         cand = sep | (64'd1 << b);
         if (cand <= lim && sine_q30(cand << (25 - ANGLE_FRAC_BITS)) <= root) sep = cand;
      end
      return sep[SEP_W-1:0];
   endfunction

   function automatic sky_pair_t make_pair(longint r1, longint e1, longint r2, longint e2);
      sky_pair_t p;
      p.ra_first   = RA_W'(r1);
      p.dec_first  = DEC_W'(e1);
      p.ra_second  = RA_W'(r2);
      p.dec_second = DEC_W'(e2);
      return p;
   endfunction

   // Mostly sky-valid positions, with some raw full-width values so that
   // every bit toggles and out-of-range RA and declination get exercised.
   function automatic sky_pair_t random_pair();
      sky_pair_t p;
      int unsigned kind;
      kind = $urandom_range(0, 9);
      p.ra_first   = RA_W'($urandom_range(0, 23592959));
      p.dec_first  = DEC_W'($urandom_range(0, 11796480) - 5898240);
      p.ra_second  = RA_W'($urandom_range(0, 23592959));
      p.dec_second = DEC_W'($urandom_range(0, 11796480) - 5898240);
      if (kind == 0) begin
         p = sky_pair_t'({$urandom, $urandom, $urandom});
      end else if (kind == 1) begin
         // Close neighbors, where the small-angle behavior matters.
         p.ra_second  = RA_W'(p.ra_first + $urandom_range(0, 4096) - 2048);
         p.dec_second = DEC_W'(p.dec_first + $urandom_range(0, 4096) - 2048);
      end else if (kind == 2) begin
         // Near-antipodal pairs, which push the haversine up to one.
         p.ra_second  = RA_W'(p.ra_first + 11796480 + $urandom_range(0, 512) - 256);
         p.dec_second = DEC_W'(-p.dec_first + $urandom_range(0, 512) - 256);
      end
      return p;
   endfunction

   initial begin
      clock = 1'b0;
      forever #(PERIOD / 2) clock = ~clock;
   end

   // Driver: keeps a beat steady until it is accepted, idling in bursts
   // except near the end of the run.
   int req_idle_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_idle_left > 0) begin
            req_idle_left <= req_idle_left - 1;
            req_valid     <= 1'b0;
         end else if (pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            req_idle_left <= $urandom_range(1, 16) - 1;
            req_valid     <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            sky_pair_t p;
            p = pending_pairs.pop_front();
            req_valid      <= 1'b1;
            req_ra_first   <= p.ra_first;
            req_dec_first  <= p.dec_first;
            req_ra_second  <= p.ra_second;
            req_dec_second <= p.dec_second;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: records an expectation for each accepted request beat and
   // checks each accepted response beat against the oldest one.
   int rsp_idle_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            expected_separations.push_back(predict_separation(
               make_pair(req_ra_first, req_dec_first, req_ra_second, req_dec_second)));
         if (rsp_valid && rsp_ready) begin
            if (expected_separations.size() == 0) begin
               $error("separation: unexpected beat, actual %0d", rsp_separation);
               error_count++;
            end else begin
               logic [SEP_W-1:0] want;
               want = expected_separations.pop_front();
               if (rsp_separation !== want) begin
                  $error("separation: expected %0d actual %0d", want, rsp_separation);
                  error_count++;
               end
            end
         end
         if (rsp_idle_left > 0) begin
            rsp_idle_left <= rsp_idle_left - 1;
            rsp_ready     <= 1'b0;
         end else if (pending_pairs.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
            rsp_idle_left <= $urandom_range(1, 16) - 1;
            rsp_ready     <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      req_valid      = 1'b0;
      rsp_ready      = 1'b0;
      req_ra_first   = '0;
      req_dec_first  = '0;
      req_ra_second  = '0;
      req_dec_second = '0;
      reset          = 1'b1;

      // Directed pairs: coincident points, poles, antipodes, field extremes,
      // declinations beyond 90 degree and a negative cosine product.
      pending_pairs.push_back(make_pair(0, 0, 0, 0));
      pending_pairs.push_back(make_pair(23592959, 5898240, 23592959, 5898240));
      pending_pairs.push_back(make_pair(0, 0, 11796480, 0));
      pending_pairs.push_back(make_pair(0, 5898240, 0, -5898240));
      pending_pairs.push_back(make_pair(1234567, 5898240, 9876543, 5898240));
      pending_pairs.push_back(make_pair(0, -5898240, 23592959, -5898240));
      pending_pairs.push_back(make_pair(0, 0, 5898240, 0));
      pending_pairs.push_back(make_pair(0, 0, 0, 1));
      pending_pairs.push_back(make_pair(0, 0, 1, 0));
      pending_pairs.push_back(make_pair(33554431, 0, 0, 0));
      pending_pairs.push_back(make_pair(33554431, 8388607, 0, -8388608));
      pending_pairs.push_back(make_pair(0, -8388608, 0, 8388607));
      pending_pairs.push_back(make_pair(100, 7864320, 200, 0));
      pending_pairs.push_back(make_pair(0, 8000000, 11796480, 1000000));
      pending_pairs.push_back(make_pair(0, 11796480, 0, 0));
      pending_pairs.push_back(make_pair(23592959, -7000000, 0, 5898240));
      pending_pairs.push_back(make_pair(11796480, 2949120, 0, -2949120));
      pending_pairs.push_back(make_pair(11796481, 1, 0, 0));
      pending_pairs.push_back(make_pair(0, 5898239, 11796480, 5898239));
      pending_pairs.push_back(make_pair(16777216, 4194304, 8388608, -4194304));
      for (int i = 0; i < N_RANDOM; i++) pending_pairs.push_back(random_pair());

      repeat (RESET_CYC) @(posedge clock);
      reset <= 1'b0;

      // Wait for every beat to go in and every result to come out.
      while (pending_pairs.size() > 0 || req_valid || expected_separations.size() > 0)
         @(posedge clock);
      repeat (LATENCY + 40) @(posedge clock);

      if (error_count == 0 && expected_separations.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire
